// File: rtl/mmcc_pkg.sv
// mmcc_pkg: shared types, constants and helper functions for the mesh mapping cost block
// no dependencies; imported by every module of the block

package mmcc_pkg;

    localparam int CoreW    = 6;
    localparam int RouterW  = 13;
    localparam int BwW      = 24;
    localparam int HopW     = 7;
    localparam int ProdW    = BwW + HopW;
    localparam int CostW    = 48;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 6;
    localparam int XyW      = 6;
    localparam int ZW       = 4;
    localparam int PlaneW   = 11;
    localparam int InDataW  = 56;
    localparam int OutDataW = 48;

    localparam logic [XyW-1:0] XyMax   = 6'd32;
    localparam logic [ZW-1:0]  ZMax    = 4'd8;
    localparam logic [XyW-1:0] XReset  = 6'd4;
    localparam logic [XyW-1:0] YReset  = 6'd4;
    localparam logic [ZW-1:0]  ZReset  = 4'd1;
    localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

    typedef enum logic [CfgIdxW-1:0] {
        CFG_X_SIZE = 2'd0,
        CFG_Y_SIZE = 2'd1,
        CFG_Z_SIZE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0] z;
        logic [4:0] y;
        logic [4:0] x;
    } coord_t;

    typedef enum logic [2:0] {
        MAP_IDLE,
        MAP_PLANE,
        MAP_CHECK,
        MAP_DIV_Z,
        MAP_DIV_Y,
        MAP_WRITE
    } map_state_t;

    typedef struct packed {
        logic busy;
        logic err_set;
    } map_stat_t;

    function automatic logic [XyW-1:0] clamp_xy(input logic [XyW-1:0] v);
        logic [XyW-1:0] r;
        if (v == '0)
            r = 6'd1;
        else if (v > XyMax)
            r = XyMax;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [ZW-1:0] clamp_z(input logic [ZW-1:0] v);
        logic [ZW-1:0] r;
        if (v == '0)
            r = 4'd1;
        else if (v > ZMax)
            r = ZMax;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [4:0] abs_diff5(input logic [4:0] a, input logic [4:0] b);
        logic [4:0] r;
        if (a > b)
            r = a - b;
        else
            r = b - a;
        return r;
    endfunction

endpackage

// File: rtl/mmcc_coord_mem.sv
// mmcc_coord_mem: per-core router coordinate store, one write port, two registered read ports
// depends on mmcc_pkg for coord_t

module mmcc_coord_mem import mmcc_pkg::*;
#(
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  coord_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output coord_t        rd_data_a,
    output coord_t        rd_data_b
);

    coord_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// File: rtl/mmcc_mapper.sv
// mmcc_mapper: splits a router number into x, y, z with a bit-serial divider and writes the store
// depends on mmcc_pkg for coord_t, map_state_t and map_stat_t

module mmcc_mapper import mmcc_pkg::*;
#(
    parameter int  MAX_CORES = 64,
    localparam int AW        = $clog2(MAX_CORES)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CoreW-1:0]   core_index,
    input  logic [RouterW-1:0] router_index,
    input  logic [XyW-1:0]     x_size,
    input  logic [XyW-1:0]     y_size,
    input  logic [ZW-1:0]      z_size,
    output map_stat_t          stat,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output coord_t             wr_data
);

    map_state_t         state_reg, state_next;
    logic [CoreW-1:0]   core_reg, core_next;
    logic [RouterW-1:0] rem_reg, rem_next;
    logic [RouterW-1:0] dv_reg, dv_next;
    logic [4:0]         q_reg, q_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [2:0]         z_reg, z_next;
    logic [PlaneW-1:0]  plane_reg, plane_next;
    coord_t             coord_reg, coord_next;

    logic [14:0]        limit;
    logic               ge;
    logic [RouterW-1:0] rem_step;
    logic               core_ok;

    assign limit    = {4'd0, plane_reg} * {11'd0, z_size};
    assign ge       = rem_reg >= dv_reg;
    assign rem_step = ge ? (rem_reg - dv_reg) : rem_reg;
    assign core_ok  = int'(core_reg) < MAX_CORES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MAP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        core_reg  <= core_next;
        rem_reg   <= rem_next;
        dv_reg    <= dv_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        z_reg     <= z_next;
        plane_reg <= plane_next;
        coord_reg <= coord_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        core_next    = core_reg;
        rem_next     = rem_reg;
        dv_next      = dv_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        z_next       = z_reg;
        plane_next   = plane_reg;
        coord_next   = coord_reg;
        stat.busy    = 1'b1;
        stat.err_set = 1'b0;
        wr_en        = 1'b0;
        case (state_reg)
            MAP_IDLE:
            begin
                stat.busy = 1'b0;
                if (start)
                begin
                    core_next  = core_index;
                    rem_next   = router_index;
                    state_next = MAP_PLANE;
                end
            end
            MAP_PLANE:
            begin
                plane_next = {5'd0, x_size} * {5'd0, y_size};
                state_next = MAP_CHECK;
            end
            MAP_CHECK:
            begin
                if ({2'd0, rem_reg} >= limit)
                begin
                    stat.err_set = 1'b1;
                    coord_next   = '0;
                    state_next   = MAP_WRITE;
                end
                else
                begin
                    dv_next    = {plane_reg, 2'b00};
                    cnt_next   = 3'd2;
                    q_next     = '0;
                    state_next = MAP_DIV_Z;
                end
            end
            MAP_DIV_Z:
            begin
                rem_next = rem_step;
                dv_next  = dv_reg >> 1;
                q_next   = {q_reg[3:0], ge};
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    z_next     = {q_reg[1:0], ge};
                    dv_next    = {3'd0, x_size, 4'd0};
                    q_next     = '0;
                    cnt_next   = 3'd4;
                    state_next = MAP_DIV_Y;
                end
            end
            MAP_DIV_Y:
            begin
                rem_next = rem_step;
                dv_next  = dv_reg >> 1;
                q_next   = {q_reg[3:0], ge};
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    coord_next.z = z_reg;
                    coord_next.y = {q_reg[3:0], ge};
                    coord_next.x = rem_step[4:0];
                    state_next   = MAP_WRITE;
                end
            end
            MAP_WRITE:
            begin
                wr_en      = core_ok;
                state_next = MAP_IDLE;
            end
            default:
            begin
                state_next = MAP_IDLE;
            end
        endcase
    end

    assign wr_addr = AW'(core_reg);
    assign wr_data = coord_reg;

endmodule

// File: rtl/mmcc_cost_pipe.sv
// mmcc_cost_pipe: edge pipeline (hop distance, multiply, saturating add) and result register
// depends on mmcc_pkg for coord_t and widths

module mmcc_cost_pipe import mmcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                edge_start,
    input  logic                src_ok,
    input  logic                dst_ok,
    input  logic [BwW-1:0]      bandwidth,
    input  logic                last_edge,
    input  coord_t              rd_data_a,
    input  coord_t              rd_data_b,
    input  logic                err_set,
    output logic                adv,
    output logic                pipe_empty,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    output logic                m_tuser
);

    logic v1_reg, v2_reg, v3_reg;
    logic last1_reg, last2_reg, last3_reg;
    logic aok1_reg, bok1_reg;
    logic [BwW-1:0]   bw1_reg, bw2_reg;
    logic [HopW-1:0]  hops2_reg;
    logic [ProdW-1:0] prod3_reg;
    logic [CostW-1:0] cost_reg, cost_next;
    logic             err_reg, err_next;
    logic             out_valid_reg, out_valid_next;
    logic [CostW-1:0] out_cost_reg, out_cost_next;
    logic             out_err_reg, out_err_next;

    coord_t           ca, cb;
    logic [HopW-1:0]  hops;
    logic [ProdW-1:0] prod;
    logic [CostW:0]   sum;
    logic [CostW-1:0] sat;

    assign adv        = !out_valid_reg || m_tready;
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    assign ca   = aok1_reg ? rd_data_a : '0;
    assign cb   = bok1_reg ? rd_data_b : '0;
    assign hops = HopW'(abs_diff5(ca.x, cb.x)) + HopW'(abs_diff5(ca.y, cb.y))
                + HopW'(abs_diff5({2'd0, ca.z}, {2'd0, cb.z}));
    assign prod = {HopW'(0), bw2_reg} * {BwW'(0), hops2_reg};
    assign sum  = {1'b0, cost_reg} + (CostW+1)'(prod3_reg);
    assign sat  = sum[CostW] ? CostMax : sum[CostW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            cost_reg      <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= edge_start;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
            out_valid_reg <= out_valid_next;
            cost_reg      <= cost_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bw1_reg   <= bandwidth;
            last1_reg <= last_edge;
            aok1_reg  <= src_ok;
            bok1_reg  <= dst_ok;
            bw2_reg   <= bw1_reg;
            last2_reg <= last1_reg;
            hops2_reg <= hops;
            prod3_reg <= prod;
            last3_reg <= last2_reg;
        end
        out_cost_reg <= out_cost_next;
        out_err_reg  <= out_err_next;
    end

    always_comb
    begin
        cost_next      = cost_reg;
        err_next       = err_reg | err_set;
        out_valid_next = out_valid_reg;
        out_cost_next  = out_cost_reg;
        out_err_next   = out_err_reg;
        if (adv)
        begin
            out_valid_next = 1'b0;
            if (v3_reg)
            begin
                if (last3_reg)
                begin
                    out_valid_next = 1'b1;
                    out_cost_next  = sat;
                    out_err_next   = err_reg;
                    cost_next      = '0;
                    err_next       = 1'b0;
                end
                else
                begin
                    cost_next = sat;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cost_reg;
    assign m_tuser  = out_err_reg;

endmodule

// File: rtl/mesh_mapping_comm_cost.sv
// mesh_mapping_comm_cost: communication cost of a core-to-router mapping on a 3D mesh
// depends on mmcc_pkg, mmcc_mapper, mmcc_coord_mem and mmcc_cost_pipe
//
// channel   direction  handshake                beat contents
// s_*       in         s_tvalid / s_tready      mapping write or edge
// m_*       out        m_tvalid / m_tready      total cost and error flag
// cfg_*     in         cfg_valid / cfg_ready    mesh size register write
//
// edge beats: one per cycle unless stalled, the last loading the result register once it has
// passed v1, v2 and v3; mapping beats wait for the edge pipeline to drain, then run the mapper's
// plane, check, bit-serial z and y divide and write states (divide skipped outside the mesh)
// edges stall while the result register holds an untaken beat or a mapping is running
// reset clears control, cost and error and sets the sizes to 4 x 4 x 1; the coordinate store is not cleared

module mesh_mapping_comm_cost import mmcc_pkg::*;
#(
    parameter int MAX_CORES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // core_index, router_index, src_core, dst_core, bandwidth, pad
    input  logic                s_tuser,   // action
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // total_cost
    output logic                m_tuser,   // placement_error
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_CORES);

    logic [XyW-1:0] x_size_reg, y_size_reg;
    logic [ZW-1:0]  z_size_reg;

    logic [CoreW-1:0]   core_index, src_core, dst_core;
    logic [RouterW-1:0] router_index;
    logic [BwW-1:0]     bandwidth;

    map_stat_t     stat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    coord_t        wr_data;
    coord_t        rd_data_a, rd_data_b;
    logic          adv, pipe_empty;
    logic          map_start, edge_start;

    assign core_index   = s_tdata[5:0];
    assign router_index = s_tdata[18:6];
    assign src_core     = s_tdata[24:19];
    assign dst_core     = s_tdata[30:25];
    assign bandwidth    = s_tdata[54:31];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_size_reg <= XReset;
            y_size_reg <= YReset;
            z_size_reg <= ZReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_X_SIZE: x_size_reg <= cfg_data;
                CFG_Y_SIZE: y_size_reg <= cfg_data;
                CFG_Z_SIZE: z_size_reg <= cfg_data[ZW-1:0];
                default:    ;
            endcase
        end
    end

    assign s_tready   = !stat.busy && (s_tuser ? adv : pipe_empty);
    assign map_start  = s_tvalid && s_tready && !s_tuser;
    assign edge_start = s_tvalid && s_tready && s_tuser;

    mmcc_mapper #(.MAX_CORES(MAX_CORES)) u_mapper
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (map_start),
        .core_index   (core_index),
        .router_index (router_index),
        .x_size       (clamp_xy(x_size_reg)),
        .y_size       (clamp_xy(y_size_reg)),
        .z_size       (clamp_z(z_size_reg)),
        .stat         (stat),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    mmcc_coord_mem #(.DEPTH(MAX_CORES)) u_mem
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (adv),
        .rd_addr_a (AW'(src_core)),
        .rd_addr_b (AW'(dst_core)),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    mmcc_cost_pipe u_pipe
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_start (edge_start),
        .src_ok     (int'(src_core) < MAX_CORES),
        .dst_ok     (int'(dst_core) < MAX_CORES),
        .bandwidth  (bandwidth),
        .last_edge  (s_tlast),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .err_set    (stat.err_set),
        .adv        (adv),
        .pipe_empty (pipe_empty),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// File: rtl/mmcc_checker.sv
// mmcc_checker: port-level assertions for mesh_mapping_comm_cost, attached by bind
// depends on mmcc_pkg for widths and on the top level's port names

module mmcc_checker import mmcc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic                m_tuser,
    input logic                cfg_valid,
    input logic                cfg_ready
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // a mapping beat keeps the input closed for the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("input ready right after a mapping beat");

    // a mapping beat never enters behind an edge still in the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !(s_tvalid && s_tready && !s_tuser))
        else $error("mapping beat accepted behind an edge");

    // config writes never stall
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind mesh_mapping_comm_cost mmcc_checker u_mmcc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// File: tb/mesh_mapping_comm_cost_tb.sv
// mesh_mapping_comm_cost_tb: self-checking bench for the mesh mapping communication cost block
// streams mapping writes and edges with random pacing, predicts totals and error flags in-bench
// depends on mmcc_pkg and mesh_mapping_comm_cost

module mesh_mapping_comm_cost_tb;
    import mmcc_pkg::*;

    localparam int StallLimit = 3000;
    localparam int SettleCycles = 40;
    localparam int CornerEdges = 12;

    typedef struct {
        bit        action;
        bit [5:0]  core;
        bit [12:0] router;
        bit [5:0]  src;
        bit [5:0]  dst;
        bit [23:0] bw;
        bit        last;
    } beat_t;

    typedef struct {
        bit [CostW-1:0] cost;
        bit             err;
    } total_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    beat_t  beat_queue[$];
    total_t cost_due[$];
    int     mapped_ids[$];
    bit     mapped[64];

    beat_t  tx_beat;
    beat_t  nb;
    int     tx_gap = 0;
    int     rx_wait = 0;
    int     rx_draw;
    total_t want;
    int     fails = 0;
    int     idle_cycles = 0;
    bit     calm = 1'b0;

    // shadow of the mesh registers and the scoring state
    bit [5:0]          mx = 6'd4;
    bit [5:0]          my = 6'd4;
    bit [3:0]          mz = 4'd1;
    coord_t            placed[64];
    longint unsigned   cost_acc = 0;
    bit                err_seen = 1'b0;

    mesh_mapping_comm_cost dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int span(input int v, input int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int mesh_routers();
        return span(int'(mx), 32) * span(int'(my), 32) * span(int'(mz), 8);
    endfunction

    function automatic int axis_gap(input int p, input int q);
        return (p > q) ? p - q : q - p;
    endfunction

    function automatic int pace();
        if (calm)
            return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
    endfunction

    // cost and error update for one accepted beat
    function automatic void score_beat(input beat_t b);
        int              xs;
        int              ys;
        int              zs;
        int              plane;
        int              rest;
        int              hops;
        coord_t          c;
        coord_t          a;
        coord_t          d;
        longint unsigned prod;
        total_t          t;
        xs = span(int'(mx), 32);
        ys = span(int'(my), 32);
        zs = span(int'(mz), 8);
        if (b.action == 1'b0)
        begin
            plane = xs * ys;
            c = '0;
            if (int'(b.router) >= plane * zs)
                err_seen = 1'b1;
            else
            begin
                c.z = 3'(int'(b.router) / plane);
                rest = int'(b.router) - int'(c.z) * plane;
                c.y = 5'(rest / xs);
                c.x = 5'(rest - int'(c.y) * xs);
            end
            placed[b.core] = c;
        end
        else
        begin
            a = placed[b.src];
            d = placed[b.dst];
            hops = axis_gap(int'(a.x), int'(d.x)) + axis_gap(int'(a.y), int'(d.y))
                 + axis_gap(int'(a.z), int'(d.z));
            prod = 64'(b.bw) * 64'(hops);
            if (prod >= 64'(CostMax) - cost_acc)
                cost_acc = 64'(CostMax);
            else
                cost_acc = cost_acc + prod;
            if (b.last)
            begin
                t.cost = cost_acc[CostW-1:0];
                t.err = err_seen;
                cost_due.push_back(t);
                cost_acc = '0;
                err_seen = 1'b0;
            end
        end
    endfunction

    function automatic void push_map(input int core, input int router, input bit last);
        beat_t b;
        b.action = 1'b0;
        b.core = 6'(core);
        b.router = 13'(router);
        b.src = 6'($urandom_range(0, 63));
        b.dst = 6'($urandom_range(0, 63));
        b.bw = 24'($urandom);
        b.last = last;
        beat_queue.push_back(b);
        if (!mapped[core])
        begin
            mapped[core] = 1'b1;
            mapped_ids.push_back(core);
        end
    endfunction

    function automatic void push_edge(input int src, input int dst, input bit [23:0] bw,
                                      input bit last);
        beat_t b;
        b.action = 1'b1;
        b.core = 6'($urandom_range(0, 63));
        b.router = 13'($urandom_range(0, 8191));
        b.src = 6'(src);
        b.dst = 6'(dst);
        b.bw = bw;
        b.last = last;
        beat_queue.push_back(b);
    endfunction

    // sender side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                score_beat(tx_beat);
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (beat_queue.size() > 0)
                begin
                    nb = beat_queue.pop_front();
                    tx_beat <= nb;
                    s_tdata <= {1'b0, nb.bw, nb.dst, nb.src, nb.router, nb.core};
                    s_tuser <= nb.action;
                    s_tlast <= nb.last;
                    s_tvalid <= 1'b1;
                    tx_gap <= pace();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver side and checking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cost_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected total beat: cost %h error %b", m_tdata, m_tuser);
                end
                else
                begin
                    want = cost_due.pop_front();
                    if (m_tdata !== want.cost || m_tuser !== want.err)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("total mismatch: cost exp %h got %h, error exp %b got %b",
                                     want.cost, m_tdata, want.err, m_tuser);
                    end
                end
                rx_draw = pace();
                rx_wait <= rx_draw;
                m_tready <= (rx_draw == 0);
            end
            else if (rx_wait > 0)
            begin
                rx_wait <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit)
            begin
                $display("mesh_mapping_comm_cost verification failed");
                $finish;
            end
        end
    end

    task automatic settle();
        while (beat_queue.size() != 0 || s_tvalid || cost_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input bit [5:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_X_SIZE: mx = val;
            CFG_Y_SIZE: my = val;
            CFG_Z_SIZE: mz = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_mesh(input bit [5:0] x, input bit [5:0] y, input bit [5:0] z);
        settle();
        write_reg(CFG_X_SIZE, x);
        write_reg(CFG_Y_SIZE, y);
        write_reg(CFG_Z_SIZE, z);
    endtask

    task automatic random_phase(input int n);
        int        k;
        int        lim;
        int        r;
        int        s;
        int        d;
        bit [23:0] bw;
        calm = ($urandom_range(0, 3) == 0);
        lim = mesh_routers();
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                : $urandom_range(0, lim - 1);
                push_map($urandom_range(0, 63), r, 1'($urandom_range(0, 1)));
            end
            else
            begin
                s = mapped_ids[$urandom_range(0, mapped_ids.size() - 1)];
                d = ($urandom_range(0, 9) == 0) ? s
                    : mapped_ids[$urandom_range(0, mapped_ids.size() - 1)];
                case ($urandom_range(0, 5))
                    0: bw = '0;
                    1: bw = '1;
                    default: bw = 24'($urandom);
                endcase
                push_edge(s, d, bw, $urandom_range(0, 5) == 0);
            end
        end
    endtask

    initial
    begin : stimulus
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset mesh of 4 x 4 x 1
        push_map(0, 0, 1'b0);
        push_map(63, 15, 1'b0);
        push_map(21, 5, 1'b0);
        push_map(42, 10, 1'b0);
        push_map(1, 16, 1'b0);
        push_map(2, 8191, 1'b0);
        push_edge(0, 63, 24'hFFFFFF, 1'b0);
        push_edge(63, 0, 24'h000000, 1'b0);
        push_edge(21, 42, 24'h000001, 1'b1);
        push_edge(0, 0, 24'hFFFFFF, 1'b1);
        push_map(5, 3, 1'b1);
        push_edge(63, 21, 24'h800000, 1'b0);
        push_edge(5, 1, 24'h0000FF, 1'b0);
        push_edge(2, 63, 24'h123456, 1'b1);
        random_phase(75);

        set_mesh(6'd32, 6'd32, 6'd8);
        random_phase(75);
        set_mesh(6'd1, 6'd1, 6'd1);
        random_phase(60);
        set_mesh(6'd0, 6'd0, 6'd0);
        random_phase(60);
        set_mesh(6'd63, 6'd63, 6'h3A);
        random_phase(75);
        set_mesh(6'd5, 6'd7, 6'd3);
        random_phase(75);
        set_mesh(6'd3, 6'd1, 6'd8);
        random_phase(60);
        set_mesh(6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)),
                 6'($urandom_range(1, 8)));
        random_phase(75);
        set_mesh(6'd17, 6'd2, 6'd5);
        random_phase(60);

        // opposite corners of the largest mesh at full bandwidth
        set_mesh(6'd32, 6'd32, 6'd8);
        calm = 1'b1;
        push_map(0, 0, 1'b0);
        push_map(1, 8191, 1'b0);
        for (k = 0; k < CornerEdges; k++)
            push_edge(0, 1, 24'hFFFFFF, k == CornerEdges - 1);
        push_edge(1, 0, 24'h000100, 1'b1);

        settle();
        if (fails == 0 && cost_due.size() == 0)
            $display("mesh_mapping_comm_cost verification clean");
        else
            $display("mesh_mapping_comm_cost verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mmcc_pkg.sv
rtl/mmcc_coord_mem.sv
rtl/mmcc_mapper.sv
rtl/mmcc_cost_pipe.sv
rtl/mesh_mapping_comm_cost.sv
rtl/mmcc_checker.sv
tb/mesh_mapping_comm_cost_tb.sv
